[rtl/core/assert_macros.svh]
// Assertion macros used by the placement core checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CCP_ASSERT_CR(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ccp assertion failed");

// Concurrent assertion on the block clock and reset.
`define CCP_ASSERT(label, prop) `CCP_ASSERT_CR(label, clk_i, rst_ni, prop)

`endif

[rtl/core/ccp_pkg.sv]
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared widths, codes and controller/datapath bundles of the placement core.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int unsigned NODES   = 32;
  localparam int unsigned NODE_W  = 5;
  localparam int unsigned CENTERS = 8;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned CNT_W   = 6;   // member count, node count
  localparam int unsigned SIDE_W  = 21;  // row sum of up to 32 distances
  localparam int unsigned MEAN_W  = 37;  // Q.16 mean
  localparam int unsigned SUM_W   = 42;  // sum of 32 means
  localparam int unsigned X_W     = 54;  // mean times weight
  localparam int unsigned ACC_W   = 92;  // weighted latency
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFGI_W  = 2;

  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] CMD_DIST   = 2'd0;
  localparam logic [1:0] CMD_CENTER = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_NODE_COUNT   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_CENTER_COUNT = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_ALPHA        = 2'd2;

  typedef enum logic [1:0] {DIV_INTRA, DIV_INTER, DIV_AVG_IN, DIV_AVG_OUT} div_sel_e;
  typedef enum logic [1:0] {MAC_CA, MAC_CB, MAC_LAT} mac_sel_e;

  typedef struct packed {
    logic              wr_dist;
    logic              wr_center;
    logic              run_init;
    logic              asg_rd;
    logic              asg_cmp;
    logic              asg_last;
    logic              mean_start;
    logic              mean_rd;
    logic              mean_acc;
    logic              div_start;
    logic              div_take;
    div_sel_e          div_sel;
    logic              mac_start;
    logic              mac_take;
    mac_sel_e          mac_sel;
    logic              ch_start;
    logic              ch_test;
    logic              emit_node;
    logic              emit_cl;
    logic              emit_last;
    logic [NODE_W-1:0] idx_i;
    logic [NODE_W-1:0] idx_j;
  } ccp_cmd_t;

  typedef struct packed {
    logic              div_done;
    logic              mac_done;
    logic              member_hit;
    logic              out_free;
    logic [NODE_W-1:0] n_m1;
    logic [CIDX_W-1:0] k_m1;
  } ccp_sts_t;

endpackage

[rtl/core/ccp_ram.sv]
// ----------------------------------------------------------------------------
// ccp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ccp_div.sv]
// ----------------------------------------------------------------------------
// ccp_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module ccp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ccp_pkg::SUM_W-1:0]  dividend_i,
  input  logic [ccp_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [ccp_pkg::SUM_W-1:0]  quotient_o
);

  localparam int DW = ccp_pkg::SUM_W;
  localparam int VW = ccp_pkg::CNT_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [VW-1:0] dvs_q, rem_q;
  logic [VW:0]   r2;
  logic          ge;
  logic [VW-1:0] rem_d;

  always_comb begin
    r2    = {rem_q, dvd_q[DW-1]};
    ge    = r2 >= {1'b0, dvs_q};
    rem_d = ge ? VW'(r2 - {1'b0, dvs_q}) : r2[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

[rtl/core/ccp_mac.sv]
// ----------------------------------------------------------------------------
// ccp_mac
// Bit-serial dual multiply-add: x*mx + y*my, multiplier bits MSB first.
// ----------------------------------------------------------------------------
module ccp_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ccp_pkg::X_W-1:0]     x_i,
  input  logic [ccp_pkg::X_W-1:0]     y_i,
  input  logic [ccp_pkg::MEAN_W-1:0]  mx_i,
  input  logic [ccp_pkg::MEAN_W-1:0]  my_i,
  output logic                        done_o,
  output logic [ccp_pkg::ACC_W-1:0]   acc_o
);

  localparam int AW = ccp_pkg::ACC_W;
  localparam int XW = ccp_pkg::X_W;
  localparam int MW = ccp_pkg::MEAN_W;
  localparam int CW = $clog2(MW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] x_q, y_q;
  logic [MW-1:0] mx_q, my_q;
  logic [AW-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = {acc_q[AW-2:0], 1'b0}
          + (mx_q[MW-1] ? AW'(x_q) : '0)
          + (my_q[MW-1] ? AW'(y_q) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(MW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      mx_q  <= mx_i;
      my_q  <= my_i;
      acc_q <= '0;
    end else if (busy_q) begin
      mx_q  <= {mx_q[MW-2:0], 1'b0};
      my_q  <= {my_q[MW-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

[rtl/core/ccp_ctrl.sv]
// ----------------------------------------------------------------------------
// ccp_ctrl
// Run sequencer: assignment, mean, average, weight, node result and choice phases.
// ----------------------------------------------------------------------------
module ccp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  ccp_pkg::ccp_sts_t sts_i,
  output ccp_pkg::ccp_cmd_t cmd_o
);

  localparam int NW = ccp_pkg::NODE_W;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ASG_RD   = 5'd1;
  localparam logic [4:0] S_ASG_CMP  = 5'd2;
  localparam logic [4:0] S_M_START  = 5'd3;
  localparam logic [4:0] S_M_RD     = 5'd4;
  localparam logic [4:0] S_M_ACC    = 5'd5;
  localparam logic [4:0] S_D_INTRA  = 5'd6;
  localparam logic [4:0] S_W_INTRA  = 5'd7;
  localparam logic [4:0] S_D_INTER  = 5'd8;
  localparam logic [4:0] S_W_INTER  = 5'd9;
  localparam logic [4:0] S_D_AVGI   = 5'd10;
  localparam logic [4:0] S_W_AVGI   = 5'd11;
  localparam logic [4:0] S_D_AVGO   = 5'd12;
  localparam logic [4:0] S_W_AVGO   = 5'd13;
  localparam logic [4:0] S_C_CA     = 5'd14;
  localparam logic [4:0] S_W_CA     = 5'd15;
  localparam logic [4:0] S_C_CB     = 5'd16;
  localparam logic [4:0] S_W_CB     = 5'd17;
  localparam logic [4:0] S_E_NODE   = 5'd18;
  localparam logic [4:0] S_CH_START = 5'd19;
  localparam logic [4:0] S_CH_TEST  = 5'd20;
  localparam logic [4:0] S_CH_WAIT  = 5'd21;
  localparam logic [4:0] S_E_CL     = 5'd22;

  logic [4:0]    state_q, state_d;
  logic [NW-1:0] i_q, i_d, j_q, j_d;
  logic          i_last, j_last_n, j_last_k;

  assign i_last   = i_q == sts_i.n_m1;
  assign j_last_n = j_q == sts_i.n_m1;
  assign j_last_k = j_q == NW'(sts_i.k_m1);

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    cmd_o        = '0;
    cmd_o.idx_i  = i_q;
    cmd_o.idx_j  = j_q;
    cmd_o.div_sel = ccp_pkg::DIV_INTRA;
    cmd_o.mac_sel = ccp_pkg::MAC_LAT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (command_i)
            ccp_pkg::CMD_DIST:   cmd_o.wr_dist = 1'b1;
            ccp_pkg::CMD_CENTER: cmd_o.wr_center = 1'b1;
            ccp_pkg::CMD_RUN: begin
              cmd_o.run_init = 1'b1;
              i_d     = '0;
              j_d     = '0;
              state_d = S_ASG_RD;
            end
            default: ;
          endcase
        end
      end
      S_ASG_RD: begin
        cmd_o.asg_rd = 1'b1;
        state_d = S_ASG_CMP;
      end
      S_ASG_CMP: begin
        cmd_o.asg_cmp  = 1'b1;
        cmd_o.asg_last = j_last_k;
        state_d = S_ASG_RD;
        if (j_last_k) begin
          j_d = '0;
          if (i_last) begin
            i_d     = '0;
            state_d = S_M_START;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_M_START: begin
        cmd_o.mean_start = 1'b1;
        j_d     = '0;
        state_d = S_M_RD;
      end
      S_M_RD: begin
        cmd_o.mean_rd = 1'b1;
        state_d = S_M_ACC;
      end
      S_M_ACC: begin
        cmd_o.mean_acc = 1'b1;
        if (j_last_n) begin
          state_d = S_D_INTRA;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_M_RD;
        end
      end
      S_D_INTRA: begin
        cmd_o.div_start = 1'b1;
        state_d = S_W_INTRA;
      end
      S_W_INTRA: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = S_D_INTER;
        end
      end
      S_D_INTER: begin
        cmd_o.div_sel   = ccp_pkg::DIV_INTER;
        cmd_o.div_start = 1'b1;
        state_d = S_W_INTER;
      end
      S_W_INTER: begin
        cmd_o.div_sel = ccp_pkg::DIV_INTER;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          if (i_last) begin
            i_d     = '0;
            state_d = S_D_AVGI;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_M_START;
          end
        end
      end
      S_D_AVGI: begin
        cmd_o.div_sel   = ccp_pkg::DIV_AVG_IN;
        cmd_o.div_start = 1'b1;
        state_d = S_W_AVGI;
      end
      S_W_AVGI: begin
        cmd_o.div_sel = ccp_pkg::DIV_AVG_IN;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = S_D_AVGO;
        end
      end
      S_D_AVGO: begin
        cmd_o.div_sel   = ccp_pkg::DIV_AVG_OUT;
        cmd_o.div_start = 1'b1;
        state_d = S_W_AVGO;
      end
      S_W_AVGO: begin
        cmd_o.div_sel = ccp_pkg::DIV_AVG_OUT;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = S_C_CA;
        end
      end
      S_C_CA: begin
        cmd_o.mac_sel   = ccp_pkg::MAC_CA;
        cmd_o.mac_start = 1'b1;
        state_d = S_W_CA;
      end
      S_W_CA: begin
        cmd_o.mac_sel = ccp_pkg::MAC_CA;
        if (sts_i.mac_done) begin
          cmd_o.mac_take = 1'b1;
          state_d = S_C_CB;
        end
      end
      S_C_CB: begin
        cmd_o.mac_sel   = ccp_pkg::MAC_CB;
        cmd_o.mac_start = 1'b1;
        state_d = S_W_CB;
      end
      S_W_CB: begin
        cmd_o.mac_sel = ccp_pkg::MAC_CB;
        if (sts_i.mac_done) begin
          cmd_o.mac_take = 1'b1;
          i_d     = '0;
          state_d = S_E_NODE;
        end
      end
      S_E_NODE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_node = 1'b1;
          if (i_last) begin
            i_d     = '0;
            state_d = S_CH_START;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      S_CH_START: begin
        cmd_o.ch_start = 1'b1;
        j_d     = '0;
        state_d = S_CH_TEST;
      end
      S_CH_TEST: begin
        cmd_o.ch_test = 1'b1;
        if (sts_i.member_hit) begin
          cmd_o.mac_start = 1'b1;
          state_d = S_CH_WAIT;
        end else if (j_last_n) begin
          state_d = S_E_CL;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_CH_WAIT: begin
        if (sts_i.mac_done) begin
          cmd_o.mac_take = 1'b1;
          if (j_last_n) begin
            state_d = S_E_CL;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_CH_TEST;
          end
        end
      end
      S_E_CL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_cl   = 1'b1;
          cmd_o.emit_last = i_q == NW'(sts_i.k_m1);
          if (cmd_o.emit_last) begin
            i_d     = '0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_CH_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

[rtl/core/ccp_datapath.sv]
// ----------------------------------------------------------------------------
// ccp_datapath
// Configuration, distance store, tables, serial units and result register.
// ----------------------------------------------------------------------------
module ccp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccp_pkg::CFGI_W-1:0]    cfg_index_i,
  input  logic [ccp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [4:0]                    row_i,
  input  logic [4:0]                    col_i,
  input  logic [15:0]                   distance_i,
  input  logic [2:0]                    center_slot_i,
  input  logic [4:0]                    center_node_i,
  input  ccp_pkg::ccp_cmd_t             cmd_i,
  output ccp_pkg::ccp_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [4:0]                    item_index_o,
  output logic [4:0]                    chosen_o,
  output logic                          empty_cluster_o,
  output logic                          last_o
);

  localparam int NW  = ccp_pkg::NODE_W;
  localparam int CIW = ccp_pkg::CIDX_W;
  localparam int DW  = ccp_pkg::DIST_W;
  localparam int CTW = ccp_pkg::CNT_W;
  localparam int SDW = ccp_pkg::SIDE_W;
  localparam int MW  = ccp_pkg::MEAN_W;
  localparam int SW  = ccp_pkg::SUM_W;
  localparam int XW  = ccp_pkg::X_W;
  localparam int AW  = ccp_pkg::ACC_W;
  localparam int LW  = ccp_pkg::ALPHA_W;
  localparam int NN  = ccp_pkg::NODES;
  localparam int NC  = ccp_pkg::CENTERS;

  // configuration
  logic [5:0]    node_cnt_q;
  logic [3:0]    center_cnt_q;
  logic [LW-1:0] alpha_q;
  logic [CTW-1:0] n_use;
  logic [3:0]    k_use;
  logic [LW-1:0] a_use, a_inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q   <= 6'd1;
      center_cnt_q <= 4'd1;
      alpha_q      <= 17'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ccp_pkg::CFG_NODE_COUNT:   node_cnt_q   <= cfg_data_i[5:0];
        ccp_pkg::CFG_CENTER_COUNT: center_cnt_q <= cfg_data_i[3:0];
        ccp_pkg::CFG_ALPHA:        alpha_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (node_cnt_q == '0)              n_use = CTW'(1);
    else if (node_cnt_q > CTW'(NN))    n_use = CTW'(NN);
    else                               n_use = node_cnt_q;
    if (center_cnt_q == '0)            k_use = 4'd1;
    else if (center_cnt_q > 4'(NC))    k_use = 4'(NC);
    else                               k_use = center_cnt_q;
    a_use = (alpha_q > ccp_pkg::ONE_Q16) ? ccp_pkg::ONE_Q16 : alpha_q;
    a_inv = ccp_pkg::ONE_Q16 - a_use;
  end

  // distance store and center table
  logic [NW-1:0] ctab_q [NC];
  logic [ccp_pkg::ADDR_W-1:0] dist_raddr;
  logic [DW-1:0] dist_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_center) begin
      ctab_q[center_slot_i] <= center_node_i;
    end
  end

  assign dist_raddr = cmd_i.asg_rd ? {ctab_q[cmd_i.idx_j[CIW-1:0]], cmd_i.idx_i}
                                   : {cmd_i.idx_i, cmd_i.idx_j};

  ccp_ram #(.WIDTH(DW), .DEPTH(NN * NN)) u_dist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_dist),
    .waddr_i ({row_i, col_i}),
    .wdata_i (distance_i),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // nearest center
  logic [DW-1:0]  best_q;
  logic [CIW-1:0] cl_q, ncl;
  logic           tog_q, lt, eq;
  logic [CIW-1:0] nc_q [NN];
  logic [CTW-1:0] mcnt_q [NC];
  logic [NW-1:0]  nc_raddr;
  logic [CIW-1:0] nc_rd;

  always_comb begin
    lt  = (cmd_i.idx_j == '0) || (dist_rdata < best_q);
    eq  = lt || (dist_rdata == best_q);
    ncl = (lt || (eq && tog_q)) ? cmd_i.idx_j[CIW-1:0] : cl_q;
  end

  assign nc_raddr = (cmd_i.mean_rd || cmd_i.ch_test) ? cmd_i.idx_j : cmd_i.idx_i;
  assign nc_rd    = nc_q[nc_raddr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tog_q  <= 1'b0;
      nc_q   <= '{default: '0};
      mcnt_q <= '{default: '0};
    end else if (cmd_i.run_init) begin
      tog_q  <= 1'b0;
      mcnt_q <= '{default: '0};
    end else if (cmd_i.asg_cmp) begin
      // flip on every equal-or-new minimum
      if (eq) begin
        tog_q <= ~tog_q;
      end
      if (cmd_i.asg_last) begin
        nc_q[cmd_i.idx_i] <= ncl;
        mcnt_q[ncl]       <= mcnt_q[ncl] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.asg_cmp) begin
      best_q <= lt ? dist_rdata : best_q;
      cl_q   <= ncl;
    end
  end

  // per-node sums and means
  logic [CIW-1:0] ci_q;
  logic           hit_q;
  logic [SDW-1:0] si_q, se_q;
  logic [CTW-1:0] sz, dv_inter;
  logic [MW-1:0]  intra_q [NN];
  logic [MW-1:0]  inter_q [NN];
  logic [SW-1:0]  sum_in_q, sum_out_q;
  logic [MW-1:0]  avg_in_q, avg_out_q;
  logic [SW-1:0]  div_dvd, div_q;
  logic [CTW-1:0] div_dvs;
  logic           div_done;
  logic [MW-1:0]  v_in, v_out;

  assign sz       = mcnt_q[ci_q];
  assign dv_inter = n_use - sz;

  always_comb begin
    case (cmd_i.div_sel)
      ccp_pkg::DIV_INTRA: begin
        div_dvd = SW'({si_q, 16'd0});
        div_dvs = sz;
      end
      ccp_pkg::DIV_INTER: begin
        div_dvd = SW'({se_q, 16'd0});
        div_dvs = dv_inter;
      end
      ccp_pkg::DIV_AVG_IN: begin
        div_dvd = sum_in_q;
        div_dvs = n_use;
      end
      default: begin
        div_dvd = sum_out_q;
        div_dvs = n_use;
      end
    endcase
    v_in = (sz == '0) ? '0 : div_q[MW-1:0];
    if (k_use == 4'd1)        v_out = {se_q, 16'd0};
    else if (dv_inter == '0)  v_out = '0;
    else                      v_out = div_q[MW-1:0];
  end

  ccp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init) begin
      sum_in_q  <= '0;
      sum_out_q <= '0;
    end
    if (cmd_i.mean_start) begin
      ci_q <= nc_rd;
      si_q <= '0;
      se_q <= '0;
    end
    if (cmd_i.mean_rd) begin
      hit_q <= nc_rd == ci_q;
    end
    if (cmd_i.mean_acc) begin
      if (hit_q) si_q <= si_q + SDW'(dist_rdata);
      else       se_q <= se_q + SDW'(dist_rdata);
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        ccp_pkg::DIV_INTRA: begin
          intra_q[cmd_i.idx_i] <= v_in;
          sum_in_q             <= sum_in_q + SW'(v_in);
        end
        ccp_pkg::DIV_INTER: begin
          inter_q[cmd_i.idx_i] <= v_out;
          sum_out_q            <= sum_out_q + SW'(v_out);
        end
        ccp_pkg::DIV_AVG_IN: avg_in_q <= div_q[MW-1:0];
        default: avg_out_q <= (k_use == 4'd1) ? MW'(ccp_pkg::ONE_Q16) : div_q[MW-1:0];
      endcase
    end
  end

  // weighted latency and controller choice
  logic [XW-1:0] ca_q, cb_q, mac_x, mac_y;
  logic [MW-1:0] mac_mx, mac_my;
  logic [AW-1:0] mac_acc, lat_best_q;
  logic          mac_done, have_q;
  logic [NW-1:0] sel_q;

  always_comb begin
    case (cmd_i.mac_sel)
      ccp_pkg::MAC_CA: begin
        mac_x  = XW'(avg_out_q);
        mac_mx = MW'(a_use);
        mac_y  = '0;
        mac_my = '0;
      end
      ccp_pkg::MAC_CB: begin
        mac_x  = XW'(avg_in_q);
        mac_mx = MW'(a_inv);
        mac_y  = '0;
        mac_my = '0;
      end
      default: begin
        mac_x  = ca_q;
        mac_mx = intra_q[cmd_i.idx_j];
        mac_y  = cb_q;
        mac_my = inter_q[cmd_i.idx_j];
      end
    endcase
  end

  ccp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mac_start),
    .x_i     (mac_x),
    .y_i     (mac_y),
    .mx_i    (mac_mx),
    .my_i    (mac_my),
    .done_o  (mac_done),
    .acc_o   (mac_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.ch_start) begin
      have_q <= 1'b0;
    end else if (cmd_i.mac_take && cmd_i.mac_sel == ccp_pkg::MAC_LAT) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_take) begin
      case (cmd_i.mac_sel)
        ccp_pkg::MAC_CA: ca_q <= mac_acc[XW-1:0];
        ccp_pkg::MAC_CB: cb_q <= mac_acc[XW-1:0];
        default: begin
          // keep the first minimum
          if (!have_q || mac_acc < lat_best_q) begin
            lat_best_q <= mac_acc;
            sel_q      <= cmd_i.idx_j;
          end
        end
      endcase
    end
  end

  // result register
  logic       out_valid_q, kind_q, empty_q, last_q;
  logic [4:0] item_q, chosen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_node || cmd_i.emit_cl) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_node) begin
      kind_q   <= 1'b0;
      item_q   <= cmd_i.idx_i;
      chosen_q <= 5'(nc_rd);
      empty_q  <= 1'b0;
      last_q   <= 1'b0;
    end else if (cmd_i.emit_cl) begin
      kind_q   <= 1'b1;
      item_q   <= cmd_i.idx_i;
      chosen_q <= have_q ? sel_q : '0;
      empty_q  <= !have_q;
      last_q   <= cmd_i.emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign item_index_o    = item_q;
  assign chosen_o        = chosen_q;
  assign empty_cluster_o = empty_q;
  assign last_o          = last_q;

  always_comb begin
    sts_o            = '0;
    sts_o.div_done   = div_done;
    sts_o.mac_done   = mac_done;
    sts_o.member_hit = nc_rd == cmd_i.idx_i[CIW-1:0];
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.n_m1       = NW'(n_use - 1'b1);
    sts_o.k_m1       = CIW'(k_use - 1'b1);
  end

endmodule

[rtl/core/cluster_controller_placement_core.sv]
// ----------------------------------------------------------------------------
// cluster_controller_placement_core
// Nearest-center clustering with weighted medoid controller choice.
// ----------------------------------------------------------------------------
// Distance and center writes are accepted back to back. A run takes the
// input port off line until its last result is loaded into the output
// register. It runs assignment (one distance memory read per center), the
// per-node means (the serial divider runs twice per node, with start and
// hand-off), the averages, the two weight products, the node results, and
// per cluster a scan of all nodes plus one serial multiply-add per member
// for the controller choice. The one-read-port distance memory and the
// shared serial divider and multiplier set the pace; output stalls
// lengthen a run. A run returns n node assignments in node order, then k
// controller choices in cluster order.
// ----------------------------------------------------------------------------
module cluster_controller_placement_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  row_i,
  input  logic [4:0]  col_i,
  input  logic [15:0] distance_i,
  input  logic [2:0]  center_slot_i,
  input  logic [4:0]  center_node_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [4:0]  item_index_o,
  output logic [4:0]  chosen_o,
  output logic        empty_cluster_o,
  output logic        last_o
);

  ccp_pkg::ccp_cmd_t cmd;
  ccp_pkg::ccp_sts_t sts;

  ccp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .distance_i      (distance_i),
    .center_slot_i   (center_slot_i),
    .center_node_i   (center_node_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .item_index_o    (item_index_o),
    .chosen_o        (chosen_o),
    .empty_cluster_o (empty_cluster_o),
    .last_o          (last_o)
  );

endmodule

[rtl/core/ccp_checker.sv]
// ----------------------------------------------------------------------------
// ccp_checker
// Port-level checks of the placement core's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       kind_o,
  input logic [4:0] chosen_o,
  input logic       empty_cluster_o,
  input logic       last_o
);

  // a stalled beat stays offered
  `CCP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // node results never close a run and never flag an empty cluster
  `CCP_ASSERT(a_node_flags, out_valid_o && !kind_o |-> !last_o && !empty_cluster_o)

  // an empty cluster reports node zero
  `CCP_ASSERT(a_empty_zero, out_valid_o && kind_o && empty_cluster_o |-> chosen_o == 5'd0)

  // node results come mid-run, so input stays closed
  `CCP_ASSERT(a_busy_in_run, out_valid_o && !kind_o |-> !in_ready_o)

endmodule

bind cluster_controller_placement_core ccp_checker u_ccp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .kind_o          (kind_o),
  .chosen_o        (chosen_o),
  .empty_cluster_o (empty_cluster_o),
  .last_o          (last_o)
);
